/* src/pfrp_pkg.sv */
// Package with constants and types for the PLL frequency register planner.
package pfrp_pkg;

  localparam int unsigned FREQ_W  = 33;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned POWER_W = 6;
  localparam int unsigned N_W     = 10;
  localparam int unsigned NUM_W   = 24;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned PFD_W   = 2;

  // 10e6 = 2^7 * 78125, so the quotient is taken from fvco >> 7.
  localparam int unsigned LOW_BITS = 7;
  localparam int unsigned X_W      = FREQ_W - LOW_BITS;
  localparam int unsigned RECIP_W  = 16;
  localparam int unsigned PROD_W   = X_W + RECIP_W;
  localparam int unsigned RECIP_SH = 32;
  localparam int unsigned QM_W     = X_W + 1;
  localparam int unsigned REM_W    = 17;

  localparam logic [RECIP_W-1:0] RECIP_M    = 16'd54975;
  localparam logic [QM_W-1:0]    ODD_DIV    = 27'd78125;
  localparam logic [N_W-1:0]     N_MIN      = 10'd320;
  localparam logic [N_W-1:0]     N_MAX      = 10'd640;
  localparam logic [NUM_W-1:0]   DEN_VALUE  = 24'd10000000;

  localparam logic [FREQ_W-1:0] FREQ_MIN  = 33'd12500000;
  localparam logic [FREQ_W-1:0] FREQ_MAX  = 33'd6400000000;
  localparam logic [FREQ_W-1:0] PFD_SPLIT = 33'd4000000000;
  localparam logic [FREQ_W-1:0] TH_1      = 33'd3200000000;
  localparam logic [FREQ_W-1:0] TH_2      = 33'd1600000000;
  localparam logic [FREQ_W-1:0] TH_4      = 33'd800000000;
  localparam logic [FREQ_W-1:0] TH_8      = 33'd400000000;
  localparam logic [FREQ_W-1:0] TH_16     = 33'd200000000;
  localparam logic [FREQ_W-1:0] TH_32     = 33'd100000000;
  localparam logic [FREQ_W-1:0] TH_64     = 33'd50000000;
  localparam logic [FREQ_W-1:0] TH_128    = 33'd25000000;

  // Synthesizer register addresses.
  localparam logic [ADDR_W-1:0] ADDR_N      = 7'h24;
  localparam logic [ADDR_W-1:0] ADDR_PFD    = 7'h25;
  localparam logic [ADDR_W-1:0] ADDR_DEN_HI = 7'h26;
  localparam logic [ADDR_W-1:0] ADDR_DEN_LO = 7'h27;
  localparam logic [ADDR_W-1:0] ADDR_NUM_HI = 7'h2A;
  localparam logic [ADDR_W-1:0] ADDR_NUM_LO = 7'h2B;
  localparam logic [ADDR_W-1:0] ADDR_OUT_B  = 7'h45;
  localparam logic [ADDR_W-1:0] ADDR_DIV    = 7'h4B;
  localparam logic [ADDR_W-1:0] ADDR_START  = 7'h00;
  localparam logic [ADDR_W-1:0] ADDR_ERROR  = 7'h00;

  localparam logic [7:0]        PFD_LOW_BYTE = 8'h05;
  localparam logic [DATA_W-1:0] OUT_B_DIV    = 16'hC600;
  localparam logic [DATA_W-1:0] OUT_B_BYP    = 16'hCE00;
  localparam logic [DATA_W-1:0] DIV_BASE     = 16'h0800;
  localparam logic [DATA_W-1:0] START_DATA   = 16'h201C;

  localparam logic [POWER_W-1:0] POWER_RESET = 6'd34;

  typedef enum logic [3:0] {
    BEAT_N      = 4'd0,
    BEAT_PFD    = 4'd1,
    BEAT_DEN_HI = 4'd2,
    BEAT_DEN_LO = 4'd3,
    BEAT_NUM_HI = 4'd4,
    BEAT_NUM_LO = 4'd5,
    BEAT_OUT_B  = 4'd6,
    BEAT_DIV    = 4'd7,
    BEAT_START  = 4'd8
  } beat_t;

  typedef struct packed {
    logic              err;
    logic              bypass;
    logic [CODE_W-1:0] code;
  } plan_ctl_t;

endpackage

/* src/pll_frequency_register_planner_unit.sv */
// Top level of the PLL frequency register planner: pipeline and write sequencer.
//
//  channel | handshake           | fields                                   | dir
//  --------+---------------------+------------------------------------------+-----
//  request | req_valid req_ready | freq_hz (wanted frequency in Hz)         | in
//  result  | res_valid res_ready | reg_addr reg_data range_error last_write | out
//  config  | cfg_wr_en           | cfg_wr_data (output B power level)       | in
//
// Four pipeline registers and a plan register sit before the write sequencer, which
// loads the registered result outputs.
// A valid request gives nine result beats and an out-of-range request one, so the
// sustained rate of valid requests is set by the output sequencer.
// Up to four further requests are taken while the sequencer is busy, and a stall on
// res_ready holds the result register and backs up the pipeline.
// Reset is synchronous; it clears the valid bits, restarts the sequencer and loads the
// default power level.
module pll_frequency_register_planner_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [pfrp_pkg::FREQ_W-1:0]    freq_hz,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [pfrp_pkg::ADDR_W-1:0]    reg_addr,
  output logic [pfrp_pkg::DATA_W-1:0]    reg_data,
  output logic                           range_error,
  output logic                           last_write,
  input  logic                           cfg_wr_en,
  input  logic [pfrp_pkg::POWER_W-1:0]   cfg_wr_data
);

  // Configuration register.
  logic [pfrp_pkg::POWER_W-1:0] out_b_power;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_b_power <= pfrp_pkg::POWER_RESET;
    end else if (cfg_wr_en) begin
      out_b_power <= cfg_wr_data;
    end
  end

  // Stage valid bits and ready chain.
  logic s1_v, s2_v, s3_v, s4_v, plan_v;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, plan_rdy;
  logic out_load, beat_last;

  assign plan_rdy  = !plan_v || (out_load && beat_last);
  assign s4_rdy    = !s4_v || plan_rdy;
  assign s3_rdy    = !s3_v || s4_rdy;
  assign s2_rdy    = !s2_v || s3_rdy;
  assign s1_rdy    = !s1_v || s2_rdy;
  assign req_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      s3_v   <= 1'b0;
      s4_v   <= 1'b0;
      plan_v <= 1'b0;
    end else begin
      if (s1_rdy)   s1_v   <= req_valid;
      if (s2_rdy)   s2_v   <= s1_v;
      if (s3_rdy)   s3_v   <= s2_v;
      if (s4_rdy)   s4_v   <= s3_v;
      if (plan_rdy) plan_v <= s4_v;
    end
  end

  // Stage 1: input register, range check and divider pick.
  logic [pfrp_pkg::FREQ_W-1:0]  s1_freq;
  logic [pfrp_pkg::SHIFT_W-1:0] s1_shift;
  logic [pfrp_pkg::CODE_W-1:0]  s1_code;
  logic                         s1_bypass;
  logic                         s1_err;
  logic [pfrp_pkg::FREQ_W-1:0]  s1_fvco;

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_freq <= freq_hz;
    end
  end

  always_comb begin
    s1_bypass = 1'b0;
    priority if (s1_freq >= pfrp_pkg::TH_1) begin
      s1_shift = 4'd0; s1_code = 4'd0; s1_bypass = 1'b1;
    end else if (s1_freq >= pfrp_pkg::TH_2) begin
      s1_shift = 4'd1; s1_code = 4'd0;
    end else if (s1_freq >= pfrp_pkg::TH_4) begin
      s1_shift = 4'd2; s1_code = 4'd1;
    end else if (s1_freq >= pfrp_pkg::TH_8) begin
      s1_shift = 4'd3; s1_code = 4'd3;
    end else if (s1_freq >= pfrp_pkg::TH_16) begin
      s1_shift = 4'd4; s1_code = 4'd5;
    end else if (s1_freq >= pfrp_pkg::TH_32) begin
      s1_shift = 4'd5; s1_code = 4'd7;
    end else if (s1_freq >= pfrp_pkg::TH_64) begin
      s1_shift = 4'd6; s1_code = 4'd9;
    end else if (s1_freq >= pfrp_pkg::TH_128) begin
      s1_shift = 4'd7; s1_code = 4'd12;
    end else begin
      s1_shift = 4'd8; s1_code = 4'd14;
    end
  end

  assign s1_err  = (s1_freq < pfrp_pkg::FREQ_MIN) || (s1_freq > pfrp_pkg::FREQ_MAX);
  assign s1_fvco = s1_freq << s1_shift;

  // Stage 2: VCO frequency and control.
  logic [pfrp_pkg::FREQ_W-1:0] s2_fvco;
  pfrp_pkg::plan_ctl_t         s2_ctl;
  logic [pfrp_pkg::X_W-1:0]    s2_x;
  logic [pfrp_pkg::PFD_W-1:0]  s2_pfd;

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_fvco       <= s1_fvco;
      s2_ctl.err    <= s1_err;
      s2_ctl.bypass <= s1_bypass;
      s2_ctl.code   <= s1_code;
    end
  end

  assign s2_x   = s2_fvco[pfrp_pkg::FREQ_W-1:pfrp_pkg::LOW_BITS];
  assign s2_pfd = (s2_fvco < pfrp_pkg::PFD_SPLIT) ? 2'd1 : 2'd2;

  // Stage 3: reciprocal product estimates fvco / 10e6.
  logic [pfrp_pkg::PROD_W-1:0]   s3_prod;
  logic [pfrp_pkg::X_W-1:0]      s3_x;
  logic [pfrp_pkg::LOW_BITS-1:0] s3_low;
  logic [pfrp_pkg::PFD_W-1:0]    s3_pfd;
  pfrp_pkg::plan_ctl_t           s3_ctl;
  logic [pfrp_pkg::N_W-1:0]      s3_q0;

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_prod <= pfrp_pkg::PROD_W'(s2_x) * pfrp_pkg::PROD_W'(pfrp_pkg::RECIP_M);
      s3_x    <= s2_x;
      s3_low  <= s2_fvco[pfrp_pkg::LOW_BITS-1:0];
      s3_pfd  <= s2_pfd;
      s3_ctl  <= s2_ctl;
    end
  end

  assign s3_q0 = s3_prod[pfrp_pkg::PROD_W-1:pfrp_pkg::RECIP_SH];

  // Stage 4: quotient estimate times the odd part of the denominator.
  logic [pfrp_pkg::QM_W-1:0]     s4_qm;
  logic [pfrp_pkg::N_W-1:0]      s4_q0;
  logic [pfrp_pkg::X_W-1:0]      s4_x;
  logic [pfrp_pkg::LOW_BITS-1:0] s4_low;
  logic [pfrp_pkg::PFD_W-1:0]    s4_pfd;
  pfrp_pkg::plan_ctl_t           s4_ctl;
  logic [pfrp_pkg::QM_W-1:0]     s4_rem_full;
  logic [pfrp_pkg::QM_W-1:0]     s4_rem_adj;
  logic                          s4_fix;
  logic [pfrp_pkg::N_W-1:0]      s4_n;
  logic [pfrp_pkg::REM_W-1:0]    s4_rem;

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      s4_qm  <= pfrp_pkg::QM_W'(s3_q0) * pfrp_pkg::ODD_DIV;
      s4_q0  <= s3_q0;
      s4_x   <= s3_x;
      s4_low <= s3_low;
      s4_pfd <= s3_pfd;
      s4_ctl <= s3_ctl;
    end
  end

  // The estimate is low by at most one, so one compare and subtract finishes it.
  assign s4_rem_full = {1'b0, s4_x} - s4_qm;
  assign s4_fix      = (s4_rem_full >= pfrp_pkg::ODD_DIV);
  assign s4_rem_adj  = s4_fix ? (s4_rem_full - pfrp_pkg::ODD_DIV) : s4_rem_full;
  assign s4_n        = s4_fix ? (s4_q0 + 10'd1) : s4_q0;
  assign s4_rem      = s4_rem_adj[pfrp_pkg::REM_W-1:0];

  // Plan register feeding the write sequencer.
  logic [pfrp_pkg::N_W-1:0]   plan_n;
  logic [pfrp_pkg::NUM_W-1:0] plan_num;
  logic [pfrp_pkg::PFD_W-1:0] plan_pfd;
  pfrp_pkg::plan_ctl_t        plan_ctl;

  always_ff @(posedge clk) begin
    if (plan_rdy) begin
      plan_n   <= s4_n;
      plan_num <= {s4_rem, s4_low};
      plan_pfd <= s4_pfd;
      plan_ctl <= s4_ctl;
    end
  end

  // Write sequencer and result register.
  pfrp_pkg::beat_t             beat;
  pfrp_pkg::beat_t             beat_next;
  logic [pfrp_pkg::ADDR_W-1:0] addr_sel;
  logic [pfrp_pkg::DATA_W-1:0] data_sel;

  assign out_load  = plan_v && (!res_valid || res_ready);
  assign beat_last = plan_ctl.err || (beat == pfrp_pkg::BEAT_START);
  assign beat_next = beat_last ? pfrp_pkg::BEAT_N : pfrp_pkg::beat_t'(beat + 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      beat <= pfrp_pkg::BEAT_N;
    end else if (out_load) begin
      beat <= beat_next;
    end
  end

  always_comb begin
    unique case (beat)
      pfrp_pkg::BEAT_N: begin
        addr_sel = pfrp_pkg::ADDR_N;
        data_sel = pfrp_pkg::DATA_W'(plan_n);
      end
      pfrp_pkg::BEAT_PFD: begin
        addr_sel = pfrp_pkg::ADDR_PFD;
        data_sel = {6'd0, plan_pfd, pfrp_pkg::PFD_LOW_BYTE};
      end
      pfrp_pkg::BEAT_DEN_HI: begin
        addr_sel = pfrp_pkg::ADDR_DEN_HI;
        data_sel = {8'd0, pfrp_pkg::DEN_VALUE[23:16]};
      end
      pfrp_pkg::BEAT_DEN_LO: begin
        addr_sel = pfrp_pkg::ADDR_DEN_LO;
        data_sel = pfrp_pkg::DEN_VALUE[15:0];
      end
      pfrp_pkg::BEAT_NUM_HI: begin
        addr_sel = pfrp_pkg::ADDR_NUM_HI;
        data_sel = {8'd0, plan_num[23:16]};
      end
      pfrp_pkg::BEAT_NUM_LO: begin
        addr_sel = pfrp_pkg::ADDR_NUM_LO;
        data_sel = plan_num[15:0];
      end
      pfrp_pkg::BEAT_OUT_B: begin
        addr_sel = pfrp_pkg::ADDR_OUT_B;
        data_sel = (plan_ctl.bypass ? pfrp_pkg::OUT_B_BYP : pfrp_pkg::OUT_B_DIV)
                   | pfrp_pkg::DATA_W'(out_b_power);
      end
      pfrp_pkg::BEAT_DIV: begin
        addr_sel = pfrp_pkg::ADDR_DIV;
        data_sel = plan_ctl.bypass ? pfrp_pkg::DIV_BASE
                 : ({6'd0, plan_ctl.code, 6'd0} | pfrp_pkg::DIV_BASE);
      end
      pfrp_pkg::BEAT_START: begin
        addr_sel = pfrp_pkg::ADDR_START;
        data_sel = pfrp_pkg::START_DATA;
      end
      default: begin
        addr_sel = pfrp_pkg::ADDR_START;
        data_sel = pfrp_pkg::START_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      reg_addr    <= plan_ctl.err ? pfrp_pkg::ADDR_ERROR : addr_sel;
      reg_data    <= plan_ctl.err ? '0 : data_sel;
      range_error <= plan_ctl.err;
      last_write  <= beat_last;
    end
  end

  // A valid plan always has N in the VCO band and a remainder below 10e6.
  a_n_range: assert property (@(posedge clk) disable iff (rst)
    plan_v && !plan_ctl.err |-> plan_n >= pfrp_pkg::N_MIN && plan_n <= pfrp_pkg::N_MAX)
    else $error("integer divider out of VCO band");

  a_num_range: assert property (@(posedge clk) disable iff (rst)
    plan_v && !plan_ctl.err |-> plan_num < pfrp_pkg::DEN_VALUE)
    else $error("fractional numerator not below denominator");

  // The sequencer returns to the first beat after the last one of a request.
  a_beat_wrap: assert property (@(posedge clk) disable iff (rst)
    out_load && beat_last |=> beat == pfrp_pkg::BEAT_N)
    else $error("write sequencer did not restart");

  // An error beat is the only beat of its request.
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && range_error |-> last_write && reg_addr == pfrp_pkg::ADDR_ERROR)
    else $error("error beat not terminal");

endmodule

/* tb/pll_frequency_register_planner_unit_test.sv */
// Self-checking testbench for the PLL frequency register planner.
module pll_frequency_register_planner_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASE_ITEMS   = 76;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DIV_CODE_LSB  = 6;
  localparam logic [7:0]  PFD_SHORT     = 8'd1;
  localparam logic [7:0]  PFD_LONG      = 8'd2;

  // Channel divider code, indexed by log2 of the divide ratio.
  localparam logic [8:0][pfrp_pkg::CODE_W-1:0] DIV_CODE =
    {4'd14, 4'd12, 4'd9, 4'd7, 4'd5, 4'd3, 4'd1, 4'd0, 4'd0};

  // Lower edge of each divider band; the top entry is one past the valid range.
  localparam logic [9:0][pfrp_pkg::FREQ_W-1:0] BAND_EDGE =
    {pfrp_pkg::FREQ_MAX + 33'd1, pfrp_pkg::TH_1, pfrp_pkg::TH_2, pfrp_pkg::TH_4,
     pfrp_pkg::TH_8, pfrp_pkg::TH_16, pfrp_pkg::TH_32, pfrp_pkg::TH_64,
     pfrp_pkg::TH_128, pfrp_pkg::FREQ_MIN};

  typedef struct packed {
    logic [pfrp_pkg::ADDR_W-1:0] addr;
    logic [pfrp_pkg::DATA_W-1:0] data;
    logic                        err;
    logic                        last;
  } reg_write_t;

  class reg_write_scoreboard;
    logic [pfrp_pkg::POWER_W-1:0] power = pfrp_pkg::POWER_RESET;
    reg_write_t                   pending_writes [$];
    int unsigned                  requests   = 0;
    int unsigned                  rejected   = 0;
    int unsigned                  checked    = 0;
    int unsigned                  mismatches = 0;

    function void push(logic [pfrp_pkg::ADDR_W-1:0] addr,
                       logic [pfrp_pkg::DATA_W-1:0] data,
                       logic err, logic last);
      reg_write_t w;
      w.addr = addr;
      w.data = data;
      w.err  = err;
      w.last = last;
      pending_writes.push_back(w);
    endfunction

    // Works out the register writes that one accepted frequency must produce.
    function void plan_request(logic [pfrp_pkg::FREQ_W-1:0] f);
      logic [63:0]                 fvco;
      logic [63:0]                 n;
      logic [63:0]                 num;
      int unsigned                 sh;
      logic                        bypass;
      logic [7:0]                  pfd;
      logic [pfrp_pkg::DATA_W-1:0] div_data;
      requests++;
      if (f < pfrp_pkg::FREQ_MIN || f > pfrp_pkg::FREQ_MAX) begin
        rejected++;
        push(pfrp_pkg::ADDR_ERROR, '0, 1'b1, 1'b1);
        return;
      end
      bypass = 1'b0;
      if (f >= pfrp_pkg::TH_1) begin
        sh = 0;
        bypass = 1'b1;
      end else if (f >= pfrp_pkg::TH_2) sh = 1;
      else if (f >= pfrp_pkg::TH_4) sh = 2;
      else if (f >= pfrp_pkg::TH_8) sh = 3;
      else if (f >= pfrp_pkg::TH_16) sh = 4;
      else if (f >= pfrp_pkg::TH_32) sh = 5;
      else if (f >= pfrp_pkg::TH_64) sh = 6;
      else if (f >= pfrp_pkg::TH_128) sh = 7;
      else sh = 8;
      fvco = 64'(f) << sh;
      n    = fvco / 64'(pfrp_pkg::DEN_VALUE);
      num  = fvco - n * 64'(pfrp_pkg::DEN_VALUE);
      pfd  = (fvco < 64'(pfrp_pkg::PFD_SPLIT)) ? PFD_SHORT : PFD_LONG;
      div_data = bypass ? pfrp_pkg::DIV_BASE
                        : ((16'(DIV_CODE[sh]) << DIV_CODE_LSB) | pfrp_pkg::DIV_BASE);
      push(pfrp_pkg::ADDR_N, 16'(n), 1'b0, 1'b0);
      push(pfrp_pkg::ADDR_PFD, {pfd, pfrp_pkg::PFD_LOW_BYTE}, 1'b0, 1'b0);
      push(pfrp_pkg::ADDR_DEN_HI, 16'(pfrp_pkg::DEN_VALUE >> 16), 1'b0, 1'b0);
      push(pfrp_pkg::ADDR_DEN_LO, pfrp_pkg::DEN_VALUE[15:0], 1'b0, 1'b0);
      push(pfrp_pkg::ADDR_NUM_HI, 16'(num >> 16), 1'b0, 1'b0);
      push(pfrp_pkg::ADDR_NUM_LO, num[15:0], 1'b0, 1'b0);
      push(pfrp_pkg::ADDR_OUT_B,
           (bypass ? pfrp_pkg::OUT_B_BYP : pfrp_pkg::OUT_B_DIV) | 16'(power),
           1'b0, 1'b0);
      push(pfrp_pkg::ADDR_DIV, div_data, 1'b0, 1'b0);
      push(pfrp_pkg::ADDR_START, pfrp_pkg::START_DATA, 1'b0, 1'b1);
    endfunction

    function void compare_field(string name, logic [pfrp_pkg::ADDR_W-1:0] at,
                                logic [pfrp_pkg::DATA_W-1:0] want,
                                logic [pfrp_pkg::DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch on write to 0x%0h: expected 0x%0h, actual 0x%0h",
                 $time, name, at, want, got);
        mismatches++;
      end
    endfunction

    function void check_write(logic [pfrp_pkg::ADDR_W-1:0] addr,
                              logic [pfrp_pkg::DATA_W-1:0] data,
                              logic err, logic last);
      reg_write_t want;
      checked++;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual addr 0x%0h data 0x%0h",
                 $time, addr, data);
        mismatches++;
        return;
      end
      want = pending_writes.pop_front();
      compare_field("reg_addr", want.addr, 16'(want.addr), 16'(addr));
      compare_field("reg_data", want.addr, want.data, data);
      compare_field("range_error", want.addr, 16'(want.err), 16'(err));
      compare_field("last_write", want.addr, 16'(want.last), 16'(last));
    endfunction
  endclass

  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          req_valid   = 1'b0;
  logic                          req_ready;
  logic [pfrp_pkg::FREQ_W-1:0]   freq_hz     = '0;
  logic                          res_valid;
  logic                          res_ready   = 1'b0;
  logic [pfrp_pkg::ADDR_W-1:0]   reg_addr;
  logic [pfrp_pkg::DATA_W-1:0]   reg_data;
  logic                          range_error;
  logic                          last_write;
  logic                          cfg_wr_en   = 1'b0;
  logic [pfrp_pkg::POWER_W-1:0]  cfg_wr_data = '0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_ticket    = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  reg_write_scoreboard board = new();

  pll_frequency_register_planner_unit uut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .freq_hz     (freq_hz),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .reg_addr    (reg_addr),
    .reg_data    (reg_data),
    .range_error (range_error),
    .last_write  (last_write),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run stopped at the cycle limit with %0d writes outstanding.",
             board.pending_writes.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: checks each beat and decides ready for the next edge.
  // A new hold ticket starts a long stretch with ready held low.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        board.check_write(reg_addr, reg_data, range_error, last_write);
      end
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [pfrp_pkg::FREQ_W-1:0] random_freq();
    int unsigned                 pick;
    int unsigned                 band;
    logic [63:0]                 span;
    logic [pfrp_pkg::FREQ_W-1:0] f;
    pick = $urandom_range(99);
    if (pick < 7) begin
      return pfrp_pkg::FREQ_W'($urandom_range(32'(pfrp_pkg::FREQ_MIN - 33'd1)));
    end
    if (pick < 14) begin
      do f = {1'($urandom_range(1)), 32'($urandom())}; while (f <= pfrp_pkg::FREQ_MAX);
      return f;
    end
    if (pick < 24) begin
      // Band edges and the value just below each.
      return BAND_EDGE[$urandom_range(9)] - pfrp_pkg::FREQ_W'($urandom_range(1));
    end
    band = $urandom_range(8);
    span = 64'(BAND_EDGE[band + 1] - BAND_EDGE[band]);
    return BAND_EDGE[band] + pfrp_pkg::FREQ_W'(64'($urandom()) % span);
  endfunction

  task automatic send_request(input logic [pfrp_pkg::FREQ_W-1:0] f);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    freq_hz   <= f;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.plan_request(f);
  endtask

  task automatic wait_drain();
    req_valid <= 1'b0;
    while (board.pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_power(input logic [pfrp_pkg::POWER_W-1:0] level);
    cfg_wr_data <= level;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.power = level;
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input logic [pfrp_pkg::POWER_W-1:0] level,
                           input bit with_hold);
    write_power(level);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    if (with_hold) hold_ticket <= hold_ticket + 1;
    repeat (PHASE_ITEMS) send_request(random_freq());
    wait_drain();
  endtask

  initial begin
    logic [pfrp_pkg::FREQ_W-1:0] corner_freqs [$];
    corner_freqs = '{33'd0, 33'd12499999, 33'd12500000, 33'd24999999, 33'd25000000,
                     33'd49999999, 33'd50000000, 33'd100000000, 33'd199999999,
                     33'd200000000, 33'd399999999, 33'd400000000, 33'd799999999,
                     33'd800000000, 33'd1599999999, 33'd1600000000, 33'd1999999999,
                     33'd2000000000, 33'd3199999999, 33'd3200000000, 33'd3999999999,
                     33'd4000000000, 33'd6400000000, 33'd6400000001, 33'd8589934591};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner frequencies run at the reset power level with no idling.
    foreach (corner_freqs[i]) send_request(corner_freqs[i]);
    wait_drain();

    run_phase(0, 0, '0, 1'b1);
    run_phase(76, 0, '1, 1'b0);
    run_phase(0, 76, pfrp_pkg::POWER_W'($urandom_range(62, 1)), 1'b0);
    run_phase(18, 18, pfrp_pkg::POWER_W'($urandom_range(62, 1)), 1'b0);

    $display("Covered %0d requests (%0d out of range), %0d write beats, %0d mismatches.",
             board.requests, board.rejected, board.checked, board.mismatches);
    $display("Handshake mixes: free flow, long result hold-off, sparse requests, %s",
             "stalled results, light idling on both sides.");
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
